// File: hdl/ddps_pkg.sv
// ddps_pkg: shared types, constants and helper functions for the
// differential drive path step block
// no dependencies
package ddps_pkg;

   // fixed-point constants, Q3.13 angles
   localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
   localparam logic signed [17:0] ANG_PI      = 18'sd25736;
   localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;

   // saturation bounds in the wide working width
   localparam int WIDE_W = 66;
   localparam logic signed [WIDE_W-1:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -66'sd2147483648;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // cordic working width and iteration count
   localparam int CORDIC_W     = 36;
   localparam int CORDIC_STEPS = 14;

   // configuration register reset values and indexes
   localparam logic [30:0] TIME_STEP_RESET = 31'd655;
   localparam logic REG_WHEEL_OFFSET = 1'b0;
   localparam logic REG_TIME_STEP    = 1'b1;

   typedef struct packed {
      logic signed [31:0] path_pos_x;
      logic signed [31:0] path_pos_y;
      logic signed [31:0] path_vel_x;
      logic signed [31:0] path_vel_y;
      logic signed [15:0] perp_x;
      logic signed [15:0] perp_y;
      logic signed [31:0] perp_rate_x;
      logic signed [31:0] perp_rate_y;
      logic signed [15:0] heading;
      logic signed [31:0] speed_limit;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] left_x;
      logic signed [31:0] left_y;
      logic signed [31:0] right_x;
      logic signed [31:0] right_y;
      logic signed [31:0] left_speed;
      logic signed [31:0] right_speed;
      logic signed [31:0] left_travel;
      logic signed [31:0] right_travel;
      logic signed [31:0] param_step;
   } rsp_item_type;

   // multiplier operations; the product is registered and stored in the cycle after it is formed
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_OX,
      MUL_OY,
      MUL_DRX,
      MUL_DRY,
      MUL_LX,
      MUL_LY,
      MUL_RX,
      MUL_RY,
      MUL_MDP,
      MUL_DPL,
      MUL_DPR
   } mul_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_OX,
      S_OY,
      S_DRX,
      S_DRY,
      S_LX,
      S_LY,
      S_RX,
      S_RY,
      S_MDP,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_J_GO,
      S_J_WAIT,
      S_DPL,
      S_DPR,
      S_DP_SETTLE,
      S_SP_GO,
      S_SP_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       load_in;
      mul_op_type mul_op;
      logic       root_go;
      logic       j_go;
      logic       sp_go;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic root_busy;
      logic div_busy;
      logic out_free;
   } status_type;

   // arctangent of 2^-i in Q3.13
   function automatic logic signed [15:0] atan_entry(input logic [3:0] i);
      logic signed [15:0] v;
      case (i)
         4'd0:    v = 16'sd6434;
         4'd1:    v = 16'sd3798;
         4'd2:    v = 16'sd2007;
         4'd3:    v = 16'sd1019;
         4'd4:    v = 16'sd511;
         4'd5:    v = 16'sd256;
         4'd6:    v = 16'sd128;
         4'd7:    v = 16'sd64;
         4'd8:    v = 16'sd32;
         4'd9:    v = 16'sd16;
         4'd10:   v = 16'sd8;
         4'd11:   v = 16'sd4;
         4'd12:   v = 16'sd2;
         4'd13:   v = 16'sd1;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

   // clamp a wide signed value into 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = S32_MAX;
      end else if (v < SAT_LO) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // negate with saturation of the most negative value
   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == S32_MIN) begin
         r = S32_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   // wheel points against the heading by more than a quarter turn
   function automatic logic reversing(input logic signed [15:0] dir,
                                      input logic signed [15:0] hd);
      logic signed [17:0] d;
      d = 18'(dir) - 18'(hd);
      if (d > ANG_PI) begin
         d = d - ANG_TWO_PI;
      end else if (d < -ANG_PI) begin
         d = d + ANG_TWO_PI;
      end
      return (d > ANG_HALF_PI) || (d < -ANG_HALF_PI);
   endfunction

endpackage

// File: hdl/ddps_if.sv
// ddps_if: valid/ready channels for request and result items
// depends on ddps_pkg for the item types
interface ddps_req_if import ddps_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface ddps_rsp_if import ddps_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// File: hdl/differential_drive_path_step.sv
// differential_drive_path_step: one item in, one result out; a new item is
// taken only after the previous result has been loaded for output.
// The sequencer waits in turn on the 32-step root units with the angle
// units, then the parameter step divider, then the wheel speed dividers.
// Synchronous active-high reset clears the sequencer, the travel sums and
// the result valid; wheel_offset resets to 0 and time_step to 655.
module differential_drive_path_step import ddps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ddps_req_if.sink    req_chan,
   ddps_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [30:0] wheel_offset_ff;
   logic [30:0] time_step_ff;
   logic        csr_write;
   cmd_type     cmd;
   status_type  status;

   // configuration registers
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_offset_ff <= '0;
         time_step_ff    <= TIME_STEP_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_TIME_STEP) begin
            time_step_ff <= csr_pwdata[30:0];
         end else begin
            wheel_offset_ff <= csr_pwdata[30:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_WHEEL_OFFSET) begin
         csr_prdata = {1'b0, wheel_offset_ff};
      end else begin
         csr_prdata = {1'b0, time_step_ff};
      end
   end

   ddps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddps_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .wheel_offset (wheel_offset_ff),
      .time_step    (time_step_ff),
      .req_item     (req_chan.item),
      .rsp_item     (rsp_chan.item),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready)
   );

endmodule

// File: hdl/ddps_sqrt.sv
// ddps_sqrt: iterative 64-bit integer square root, one result bit a cycle
// depends on ddps_pkg
module ddps_sqrt import ddps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] n_ff, n_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [63:0] trial;

   // one digit of the root per cycle
   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = r_ff + bit_ff;
      if (start) begin
         n_in    = radicand;
         r_in    = '0;
         bit_in  = 64'd1 << 62;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign root = r_ff[31:0];

endmodule

// File: hdl/ddps_cordic.sv
// ddps_cordic: vectoring cordic giving the angle of a 32-bit vector in Q3.13
// depends on ddps_pkg for the arctangent table and widths
module ddps_cordic import ddps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] vec_x,
   input  logic signed [31:0] vec_y,
   output logic               busy,
   output logic signed [15:0] angle
);

   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] xs, ys, x0, y0;
   logic signed [15:0]         z_ff, z_in;
   logic [3:0]                 i_ff, i_in;
   logic                       busy_ff, busy_in;
   logic                       zero_ff, zero_in;

   // quarter-turn pre-rotation, then one micro-rotation per cycle
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      x0      = CORDIC_W'(vec_x);
      y0      = CORDIC_W'(vec_y);
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      if (start) begin
         zero_in = (vec_x == 32'sd0) && (vec_y == 32'sd0);
         i_in    = '0;
         busy_in = 1'b1;
         if (vec_x < 32'sd0) begin
            if (vec_y >= 32'sd0) begin
               x_in = y0;
               y_in = -x0;
               z_in = ANG_HALF_PI[15:0];
            end else begin
               x_in = -y0;
               y_in = x0;
               z_in = -ANG_HALF_PI[15:0];
            end
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_entry(i_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_entry(i_ff);
         end
         i_in = i_ff + 4'd1;
         if (i_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy  = busy_ff;
   assign angle = zero_ff ? 16'sd0 : z_ff;

endmodule

// File: hdl/ddps_div.sv
// ddps_div: restoring divider, 64-bit magnitude by 32-bit divisor, signed
// result saturated to 32 bits; depends on ddps_pkg
module ddps_div import ddps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        dividend,
   input  logic               negative,
   input  logic [31:0]        divisor,
   output logic               busy,
   output logic signed [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        zero_ff, zero_in;
   logic        ovf_ff, ovf_in;
   logic        neg_ff, neg_in;
   logic [32:0] trial;
   logic        fits;
   logic        ovf_now;

   // quotient of 2^31 or more saturates, so 32 steps suffice
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[31]};
      fits    = trial >= {1'b0, div_ff};
      ovf_now = dividend >= {1'b0, divisor, 31'd0};
      if (start) begin
         zero_in = (dividend == 64'd0);
         ovf_in  = ovf_now;
         neg_in  = negative;
         div_in  = divisor;
         rem_in  = ovf_now ? 32'd0 : dividend[63:32];
         quo_in  = dividend[31:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = 32'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[31:0];
         end
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
      neg_ff  <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // zero dividend, saturation by sign, or signed quotient
   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (ovf_ff) begin
         quotient = neg_ff ? S32_MIN : S32_MAX;
      end else if (neg_ff) begin
         quotient = -$signed(quo_ff);
      end else begin
         quotient = $signed(quo_ff);
      end
   end

   assign busy = busy_ff;

endmodule

// File: hdl/ddps_ctrl.sv
// ddps_ctrl: sequencer that steps the datapath through one item
// depends on ddps_pkg for state, command and status types
module ddps_ctrl import ddps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_op = MUL_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_OX;
            end
         end
         S_OX: begin
            cmd.mul_op = MUL_OX;
            state_in   = S_OY;
         end
         S_OY: begin
            cmd.mul_op = MUL_OY;
            state_in   = S_DRX;
         end
         S_DRX: begin
            cmd.mul_op = MUL_DRX;
            state_in   = S_DRY;
         end
         S_DRY: begin
            cmd.mul_op = MUL_DRY;
            state_in   = S_LX;
         end
         S_LX: begin
            cmd.mul_op = MUL_LX;
            state_in   = S_LY;
         end
         S_LY: begin
            cmd.mul_op = MUL_LY;
            state_in   = S_RX;
         end
         S_RX: begin
            cmd.mul_op = MUL_RX;
            state_in   = S_RY;
         end
         S_RY: begin
            cmd.mul_op = MUL_RY;
            state_in   = S_MDP;
         end
         S_MDP: begin
            cmd.mul_op = MUL_MDP;
            state_in   = S_ROOT_GO;
         end
         S_ROOT_GO: begin
            cmd.root_go = 1'b1;
            state_in    = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (!status.root_busy) begin
               state_in = S_J_GO;
            end
         end
         S_J_GO: begin
            cmd.j_go = 1'b1;
            state_in = S_J_WAIT;
         end
         S_J_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_DPL;
            end
         end
         S_DPL: begin
            cmd.mul_op = MUL_DPL;
            state_in   = S_DPR;
         end
         S_DPR: begin
            cmd.mul_op = MUL_DPR;
            state_in   = S_DP_SETTLE;
         end
         S_DP_SETTLE: begin
            state_in = S_SP_GO;
         end
         S_SP_GO: begin
            cmd.sp_go = 1'b1;
            state_in  = S_SP_WAIT;
         end
         S_SP_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/ddps_datapath.sv
// ddps_datapath: shared multiplier, root, angle and divider units, travel
// accumulators and the result register; depends on ddps_pkg and the units
module ddps_datapath import ddps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic [30:0]  wheel_offset,
   input  logic [30:0]  time_step,
   input  req_item_type req_item,
   output rsp_item_type rsp_item,
   output logic         rsp_valid,
   input  logic         rsp_ready
);

   req_item_type              in_ff;
   logic signed [WIDE_W-1:0]  prod_ff;
   mul_op_type                mul_op_ff;
   logic signed [32:0]        mul_a, mul_b;
   logic signed [WIDE_W-1:0]  prod_w;
   logic signed [WIDE_W-1:0]  rnd14, rnd16;
   logic [63:0]               dp_mag_w;
   logic signed [WIDE_W-1:0]  dp_w;

   logic signed [31:0] left_x_ff, left_y_ff, right_x_ff, right_y_ff;
   logic signed [31:0] lrx_ff, lry_ff, rrx_ff, rry_ff;
   logic [63:0]        accl_ff, accr_ff;
   logic signed [47:0] maxdp_ff;
   logic signed [31:0] dj_ff, dpl_ff, dpr_ff;
   logic signed [31:0] travel_l_ff, travel_l_in;
   logic signed [31:0] travel_r_ff, travel_r_in;
   rsp_item_type       out_ff;
   logic               rsp_valid_ff;

   logic [31:0]        nl, nr, big;
   logic signed [15:0] dir_l, dir_r;
   logic               sq_l_busy, sq_r_busy, co_l_busy, co_r_busy;
   logic               dv_l_busy, dv_r_busy;
   logic signed [31:0] q_l, q_r;
   logic [31:0]        dj_mag, dpl_mag, dpr_mag;
   logic [47:0]        maxdp_mag;
   logic [63:0]        dv_l_dividend;
   logic               dv_l_neg;
   logic [31:0]        dv_l_divisor;
   logic signed [31:0] spd_l, spd_r;

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_item;
      end
   end

   // shared multiplier operand select
   // the divider still holds the parameter step while both wheel products are formed
   assign dj_mag = q_l[31] ? 32'(-q_l) : 32'(q_l);
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_OX: begin
            mul_a = {2'b00, wheel_offset};
            mul_b = 33'(in_ff.perp_x);
         end
         MUL_OY: begin
            mul_a = {2'b00, wheel_offset};
            mul_b = 33'(in_ff.perp_y);
         end
         MUL_DRX: begin
            mul_a = {2'b00, wheel_offset};
            mul_b = 33'(in_ff.perp_rate_x);
         end
         MUL_DRY: begin
            mul_a = {2'b00, wheel_offset};
            mul_b = 33'(in_ff.perp_rate_y);
         end
         MUL_LX: begin
            mul_a = 33'(lrx_ff);
            mul_b = 33'(lrx_ff);
         end
         MUL_LY: begin
            mul_a = 33'(lry_ff);
            mul_b = 33'(lry_ff);
         end
         MUL_RX: begin
            mul_a = 33'(rrx_ff);
            mul_b = 33'(rrx_ff);
         end
         MUL_RY: begin
            mul_a = 33'(rry_ff);
            mul_b = 33'(rry_ff);
         end
         MUL_MDP: begin
            mul_a = 33'(in_ff.speed_limit);
            mul_b = {2'b00, time_step};
         end
         MUL_DPL: begin
            mul_a = {1'b0, dj_mag};
            mul_b = {1'b0, nl};
         end
         MUL_DPR: begin
            mul_a = {1'b0, dj_mag};
            mul_b = {1'b0, nr};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_w = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_w;
      if (reset) begin
         mul_op_ff <= MUL_NONE;
      end else begin
         mul_op_ff <= cmd.mul_op;
      end
   end

   // rounding of the registered product and wheel distance scaling
   assign rnd14    = (prod_ff + 66'sd8192) >>> 14;
   assign rnd16    = (prod_ff + 66'sd32768) >>> 16;
   assign dp_mag_w = (prod_ff[63:0] + 64'd32768) >> 16;
   assign dp_w     = dj_ff[31] ? -$signed({18'd0, dp_mag_w[47:0]})
                               : $signed({18'd0, dp_mag_w[47:0]});

   // store the product that was formed in the previous cycle
   always_ff @(posedge clock) begin
      case (mul_op_ff)
         MUL_OX: begin
            left_x_ff  <= sat32(WIDE_W'(in_ff.path_pos_x) + rnd14);
            right_x_ff <= sat32(WIDE_W'(in_ff.path_pos_x) - rnd14);
         end
         MUL_OY: begin
            left_y_ff  <= sat32(WIDE_W'(in_ff.path_pos_y) + rnd14);
            right_y_ff <= sat32(WIDE_W'(in_ff.path_pos_y) - rnd14);
         end
         MUL_DRX: begin
            lrx_ff <= sat32(WIDE_W'(in_ff.path_vel_x) + rnd16);
            rrx_ff <= sat32(WIDE_W'(in_ff.path_vel_x) - rnd16);
         end
         MUL_DRY: begin
            lry_ff <= sat32(WIDE_W'(in_ff.path_vel_y) + rnd16);
            rry_ff <= sat32(WIDE_W'(in_ff.path_vel_y) - rnd16);
         end
         MUL_LX: begin
            accl_ff <= prod_ff[63:0];
         end
         MUL_LY: begin
            accl_ff <= accl_ff + prod_ff[63:0];
         end
         MUL_RX: begin
            accr_ff <= prod_ff[63:0];
         end
         MUL_RY: begin
            accr_ff <= accr_ff + prod_ff[63:0];
         end
         MUL_MDP: begin
            maxdp_ff <= rnd16[47:0];
         end
         MUL_DPL: begin
            dpl_ff <= sat32(dp_w);
         end
         MUL_DPR: begin
            dpr_ff <= sat32(dp_w);
         end
         default: begin
         end
      endcase
   end

   // parameter step is held while the wheel distances are formed
   always_ff @(posedge clock) begin
      if (cmd.mul_op == MUL_DPL) begin
         dj_ff <= q_l;
      end
   end

   // wheel rate magnitudes and directions
   ddps_sqrt u_sqrt_l (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_go),
      .radicand (accl_ff),
      .busy     (sq_l_busy),
      .root     (nl)
   );

   ddps_sqrt u_sqrt_r (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_go),
      .radicand (accr_ff),
      .busy     (sq_r_busy),
      .root     (nr)
   );

   ddps_cordic u_cordic_l (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_go),
      .vec_x (lrx_ff),
      .vec_y (lry_ff),
      .busy  (co_l_busy),
      .angle (dir_l)
   );

   ddps_cordic u_cordic_r (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_go),
      .vec_x (rrx_ff),
      .vec_y (rry_ff),
      .busy  (co_r_busy),
      .angle (dir_r)
   );

   // divider lanes: left lane does the parameter step first, then left speed
   assign big       = (nl > nr) ? nl : nr;
   assign maxdp_mag = maxdp_ff[47] ? 48'(-maxdp_ff) : 48'(maxdp_ff);
   assign dpl_mag   = dpl_ff[31] ? 32'(-dpl_ff) : 32'(dpl_ff);
   assign dpr_mag   = dpr_ff[31] ? 32'(-dpr_ff) : 32'(dpr_ff);

   always_comb begin
      if (cmd.j_go) begin
         dv_l_dividend = {maxdp_mag, 16'd0};
         dv_l_neg      = maxdp_ff[47];
         dv_l_divisor  = big;
      end else begin
         dv_l_dividend = {16'd0, dpl_mag, 16'd0};
         dv_l_neg      = dpl_ff[31];
         dv_l_divisor  = {1'b0, time_step};
      end
   end

   ddps_div u_div_l (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.j_go | cmd.sp_go),
      .dividend (dv_l_dividend),
      .negative (dv_l_neg),
      .divisor  (dv_l_divisor),
      .busy     (dv_l_busy),
      .quotient (q_l)
   );

   ddps_div u_div_r (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sp_go),
      .dividend ({16'd0, dpr_mag, 16'd0}),
      .negative (dpr_ff[31]),
      .divisor  ({1'b0, time_step}),
      .busy     (dv_r_busy),
      .quotient (q_r)
   );

   // final speeds with reversal, travel update
   assign spd_l = reversing(dir_l, in_ff.heading) ? neg_sat(q_l) : q_l;
   assign spd_r = reversing(dir_r, in_ff.heading) ? neg_sat(q_r) : q_r;
   assign travel_l_in = travel_l_ff + dpl_ff;
   assign travel_r_in = travel_r_ff + dpr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_l_ff <= '0;
         travel_r_ff <= '0;
      end else if (cmd.finish) begin
         travel_l_ff <= travel_l_in;
         travel_r_ff <= travel_r_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_ff.left_x       <= left_x_ff;
         out_ff.left_y       <= left_y_ff;
         out_ff.right_x      <= right_x_ff;
         out_ff.right_y      <= right_y_ff;
         out_ff.left_speed   <= spd_l;
         out_ff.right_speed  <= spd_r;
         out_ff.left_travel  <= travel_l_in;
         out_ff.right_travel <= travel_r_in;
         out_ff.param_step   <= dj_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_item         = out_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign status.root_busy = sq_l_busy | sq_r_busy | co_l_busy | co_r_busy;
   assign status.div_busy  = dv_l_busy | dv_r_busy;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

// File: dv/testbench.sv
// testbench: checks differential_drive_path_step item by item against a local
// wheel kinematics predictor, over several register settings and flow-control modes
// depends on ddps_pkg, ddps_if and the block itself
module testbench;
   import ddps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_WHEEL_OFFSET = 3'd0;
   localparam logic [2:0] ADDR_TIME_STEP    = 3'd4;
   localparam longint     TOP32 = 64'sd2147483647;
   localparam longint     BOT32 = -64'sd2147483648;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ddps_req_if req_chan ();
   ddps_rsp_if rsp_chan ();

   differential_drive_path_step DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // predictor copy of registers and travel sums
   logic [30:0]  mdl_offset = '0;
   logic [30:0]  mdl_period = TIME_STEP_RESET;
   logic [31:0]  left_total = '0;
   logic [31:0]  right_total = '0;

   req_item_type pending_items[$];
   rsp_item_type expected_results[$];
   int           send_idle = 0;
   int           recv_idle = 0;
   logic         hold_trigger = 1'b0;
   int           hold_span = 0;
   int           errors = 0;
   int           items_sent = 0;
   int           results_checked = 0;

   function automatic longint clamp32(input longint v);
      if (v > TOP32) return TOP32;
      if (v < BOT32) return BOT32;
      return v;
   endfunction

   function automatic longint sign_rail(input longint v);
      if (v > 0) return TOP32;
      if (v < 0) return BOT32;
      return 0;
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // exact floor square root, bit by bit
   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // cordic vectoring, Q3.13 result
   function automatic longint wheel_angle(input longint x, input longint y);
      longint z;
      longint t;
      longint xs;
      longint ys;
      longint atan_q13[14];
      atan_q13 = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = ANG_HALF_PI;
         end else begin
            x = -y; y = t; z = -ANG_HALF_PI;
         end
      end
      for (int i = 0; i < 14; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_q13[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_q13[i];
         end
      end
      return z;
   endfunction

   function automatic bit backward(input longint dir, input longint hd);
      longint d;
      d = dir - hd;
      while (d > ANG_PI) d = d - ANG_TWO_PI;
      while (d < -ANG_PI) d = d + ANG_TWO_PI;
      return (d > ANG_HALF_PI) || (d < -ANG_HALF_PI);
   endfunction

   function automatic longint wheel_advance(input longint dj, input logic [63:0] norm);
      logic [63:0] mag;
      longint      m;
      mag = (dj < 0) ? 64'(-dj) : 64'(dj);
      m = longint'((mag * norm + 64'd32768) >> 16);
      return clamp32(dj < 0 ? -m : m);
   endfunction

   function automatic longint wheel_rate(input longint dp, input longint dir, input longint hd);
      longint v;
      if (mdl_period == 0) v = sign_rail(dp);
      else v = clamp32((dp * 65536) / longint'(mdl_period));
      if (backward(dir, hd)) v = clamp32(-v);
      return v;
   endfunction

   // expected wheel result for one item; advances the travel sums
   function automatic rsp_item_type drive_step(input req_item_type it);
      rsp_item_type r;
      longint w, ox, oy, drx, dry, lrx, lry, rrx, rry, max_dp, dj, dpl, dpr;
      logic [63:0] nl, nr, big;
      w = longint'(mdl_offset);
      ox = round_shift(w * longint'(it.perp_x), 14);
      oy = round_shift(w * longint'(it.perp_y), 14);
      drx = round_shift(w * longint'(it.perp_rate_x), 16);
      dry = round_shift(w * longint'(it.perp_rate_y), 16);
      lrx = clamp32(longint'(it.path_vel_x) + drx);
      lry = clamp32(longint'(it.path_vel_y) + dry);
      rrx = clamp32(longint'(it.path_vel_x) - drx);
      rry = clamp32(longint'(it.path_vel_y) - dry);
      nl = floor_root(64'(lrx * lrx) + 64'(lry * lry));
      nr = floor_root(64'(rrx * rrx) + 64'(rry * rry));
      big = (nl > nr) ? nl : nr;
      max_dp = round_shift(longint'(it.speed_limit) * longint'(mdl_period), 16);
      if (big == 0) dj = sign_rail(max_dp);
      else dj = clamp32((max_dp * 65536) / longint'(big));
      dpl = wheel_advance(dj, nl);
      dpr = wheel_advance(dj, nr);
      r.left_speed = 32'(wheel_rate(dpl, wheel_angle(lrx, lry), longint'(it.heading)));
      r.right_speed = 32'(wheel_rate(dpr, wheel_angle(rrx, rry), longint'(it.heading)));
      left_total = left_total + 32'(dpl);
      right_total = right_total + 32'(dpr);
      r.left_x = 32'(clamp32(longint'(it.path_pos_x) + ox));
      r.left_y = 32'(clamp32(longint'(it.path_pos_y) + oy));
      r.right_x = 32'(clamp32(longint'(it.path_pos_x) - ox));
      r.right_y = 32'(clamp32(longint'(it.path_pos_y) - oy));
      r.left_travel = left_total;
      r.right_travel = right_total;
      r.param_step = 32'(dj);
      return r;
   endfunction

   // request driver, predicts on each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.item <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(drive_step(req_chan.item));
            items_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               req_chan.item <= pending_items.pop_front();
               req_chan.valid <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with a long hold-off on request
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= hold_span;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.item;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item %h", $realtime, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (got.left_x !== want.left_x)
               $display("%0t: left_x exp %h got %h", $realtime, want.left_x, got.left_x);
            if (got.left_y !== want.left_y)
               $display("%0t: left_y exp %h got %h", $realtime, want.left_y, got.left_y);
            if (got.right_x !== want.right_x)
               $display("%0t: right_x exp %h got %h", $realtime, want.right_x, got.right_x);
            if (got.right_y !== want.right_y)
               $display("%0t: right_y exp %h got %h", $realtime, want.right_y, got.right_y);
            if (got.left_speed !== want.left_speed)
               $display("%0t: left_speed exp %h got %h", $realtime, want.left_speed,
                        got.left_speed);
            if (got.right_speed !== want.right_speed)
               $display("%0t: right_speed exp %h got %h", $realtime, want.right_speed,
                        got.right_speed);
            if (got.left_travel !== want.left_travel)
               $display("%0t: left_travel exp %h got %h", $realtime, want.left_travel,
                        got.left_travel);
            if (got.right_travel !== want.right_travel)
               $display("%0t: right_travel exp %h got %h", $realtime, want.right_travel,
                        got.right_travel);
            if (got.param_step !== want.param_step)
               $display("%0t: param_step exp %h got %h", $realtime, want.param_step,
                        got.param_step);
            if (got !== want) errors++;
         end
      end
   end

   // register write, setup then access
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_WHEEL_OFFSET) mdl_offset = data[30:0];
      else mdl_period = data[30:0];
   endtask

   // mix of extremes, small values and full range
   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(0);
         3, 4: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_perp();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it.path_pos_x = pick32();
      it.path_pos_y = pick32();
      it.path_vel_x = pick32();
      it.path_vel_y = pick32();
      it.perp_x = pick_perp();
      it.perp_y = pick_perp();
      it.perp_rate_x = pick32();
      it.perp_rate_y = pick32();
      // headings beyond a half turn now and then
      if ($urandom_range(0, 15) == 0) it.heading = 16'($urandom);
      else it.heading = 16'($signed($urandom_range(0, 51472)) - 25736);
      it.speed_limit = pick32();
      return it;
   endfunction

   function automatic req_item_type make_item(input logic [31:0] v, input logic [15:0] n,
                                              input logic [31:0] nr, input logic [15:0] hd,
                                              input logic [31:0] sp);
      req_item_type it;
      it.path_pos_x = v;
      it.path_pos_y = ~v;
      it.path_vel_x = v;
      it.path_vel_y = -v;
      it.perp_x = n;
      it.perp_y = -n;
      it.perp_rate_x = nr;
      it.perp_rate_y = ~nr;
      it.heading = hd;
      it.speed_limit = sp;
      return it;
   endfunction

   task automatic drain();
      while (pending_items.size() > 0 || expected_results.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) pending_items.push_back(random_item());
   endtask

   // sequence of register settings and flow-control modes
   initial begin
      logic [30:0] offsets[6];
      logic [30:0] periods[6];
      offsets = '{31'd0, 31'd19661, 31'h7FFF_FFFF, 31'd0, 31'd65536, 31'd1};
      periods = '{31'd655, 31'd655, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd6554};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < 6; ph++) begin
         // top bit of the write data is beyond the register and must be dropped
         csr_write(ADDR_WHEEL_OFFSET, {1'($urandom), offsets[ph]});
         csr_write(ADDR_TIME_STEP, {1'($urandom), periods[ph]});
         @(negedge clock);
         case (ph % 3)
            0: begin send_idle = 20; recv_idle = 67; end
            1: begin send_idle = 67; recv_idle = 20; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         if (ph == 1) begin
            // directed extremes and special cases
            pending_items.push_back('0);
            pending_items.push_back(make_item(32'h7FFF_FFFF, 16'sd16384, 32'h7FFF_FFFF,
                                              16'sd25736, 32'h7FFF_FFFF));
            pending_items.push_back(make_item(32'h8000_0000, -16'sd16384, 32'h8000_0000,
                                              -16'sd25736, 32'h8000_0000));
            pending_items.push_back(make_item(0, 16'sd16384, 0, 0, 32'sd65536));
            pending_items.push_back(make_item(0, 16'sd16384, 0, 0, -32'sd65536));
            pending_items.push_back(make_item(0, 16'sd0, 0, 0, 0));
            pending_items.push_back(make_item(32'sd65536, 16'sd0, 0, 16'sd25736, 32'sd65536));
            pending_items.push_back(make_item(-32'sd65536, 16'sd0, 0, 0, 32'sd65536));
            pending_items.push_back(make_item(32'sd65536, 16'sd11585, 32'sd4096,
                                              -16'sh8000, 32'sd131072));
            pending_items.push_back(make_item(32'sd65536, 16'sd11585, 32'sd4096,
                                              16'sh7FFF, -32'sd131072));
            pending_items.push_back(make_item(32'sd100, 16'sd16384, -32'sd100,
                                              16'sd12868, 32'sh8000_0000));
            pending_items.push_back(make_item(32'sd100, 16'sd16384, -32'sd100,
                                              -16'sd12869, 32'sh7FFF_FFFF));
            pending_items.push_back(make_item(32'h0000_FFFF, -16'sd1, 32'hFFFF_0000,
                                              16'sd1, 32'sd1));
            pending_items.push_back(make_item(32'hFFFF_FFFF, 16'sd1, 32'h0000_0001,
                                              -16'sd1, -32'sd1));
         end
         queue_random(230);
         if (ph == 3) begin
            // long receiver hold-off with the sender still offering items
            hold_span = 2000;
            hold_trigger = ~hold_trigger;
         end
         drain();
      end
      $display("covered %0d items over 6 register settings, %0d results checked",
               items_sent, results_checked);
      $display("modes: sender and receiver idling both ways, no idling, long output stall");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end
endmodule

// File: filelist.f
hdl/ddps_pkg.sv
hdl/ddps_if.sv
hdl/ddps_sqrt.sv
hdl/ddps_cordic.sv
hdl/ddps_div.sv
hdl/ddps_ctrl.sv
hdl/ddps_datapath.sv
hdl/differential_drive_path_step.sv
dv/testbench.sv
